// ===== rtl/core/cfpr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfpr_pkg
// Types, constants and helpers shared by the clock face pixel renderer.
// ----------------------------------------------------------------------------
package cfpr_pkg;

	localparam int CoordW  = 4;
	localparam int HourW   = 5;
	localparam int TimeW   = 6;
	localparam int ChanW   = 8;
	localparam int CfgIdxW = 1;
	localparam int CfgDataW = 8;

	localparam logic [CfgIdxW-1:0] REG_COLOR_INDEX   = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_GRADIENT_MODE = 1'd1;

	localparam logic [7:0] GRAD_RAINBOW = 8'd0;
	localparam logic [7:0] GRAD_WHITE   = 8'd1;
	localparam logic [7:0] GRAD_BLUE    = 8'd2;
	localparam logic [7:0] GRAD_WARM    = 8'd3;

	localparam logic [1:0] COLOR_INDEX_RST   = 2'd2;
	localparam logic [7:0] GRADIENT_MODE_RST = GRAD_RAINBOW;

	typedef struct packed {
		logic [CoordW-1:0] pixel_x;
		logic [CoordW-1:0] pixel_y;
		logic [HourW-1:0]  hour;
		logic [TimeW-1:0]  minute;
		logic [TimeW-1:0]  second;
	} in_req_t;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [1:0] color_index;
		logic [7:0] gradient_mode;
	} cfg_t;

	localparam rgb_t RGB_BLACK  = '{8'd0,   8'd0,   8'd0};
	localparam rgb_t RGB_WHITE  = '{8'd255, 8'd255, 8'd255};
	localparam rgb_t RGB_RED    = '{8'd255, 8'd0,   8'd0};
	localparam rgb_t RGB_GREEN  = '{8'd0,   8'd255, 8'd0};
	localparam rgb_t RGB_BLUE   = '{8'd0,   8'd0,   8'd255};
	localparam rgb_t RGB_YELLOW = '{8'd255, 8'd255, 8'd0};
	localparam rgb_t RGB_CYAN   = '{8'd0,   8'd255, 8'd255};
	localparam rgb_t RGB_ORANGE = '{8'd255, 8'd165, 8'd0};
	localparam rgb_t RGB_VIOLET = '{8'd128, 8'd0,   8'd255};

	localparam rgb_t PALETTE [0:3] = '{RGB_GREEN, RGB_WHITE, RGB_CYAN, RGB_ORANGE};

	localparam logic [2:0] FONT_ROWS [0:9][0:4] = '{
		'{3'd7, 3'd5, 3'd5, 3'd5, 3'd7},
		'{3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
		'{3'd7, 3'd1, 3'd7, 3'd4, 3'd7},
		'{3'd7, 3'd1, 3'd7, 3'd1, 3'd7},
		'{3'd5, 3'd5, 3'd7, 3'd1, 3'd1},
		'{3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
		'{3'd7, 3'd4, 3'd7, 3'd5, 3'd7},
		'{3'd7, 3'd1, 3'd1, 3'd1, 3'd1},
		'{3'd7, 3'd5, 3'd7, 3'd5, 3'd7},
		'{3'd7, 3'd5, 3'd7, 3'd1, 3'd7}
	};

	// tens digit of a value below 60
	function automatic logic [3:0] tens_of(input logic [TimeW-1:0] v);
		logic [3:0] t;
		if (v < 6'd10)      t = 4'd0;
		else if (v < 6'd20) t = 4'd1;
		else if (v < 6'd30) t = 4'd2;
		else if (v < 6'd40) t = 4'd3;
		else if (v < 6'd50) t = 4'd4;
		else                t = 4'd5;
		return t;
	endfunction

	function automatic logic [3:0] ones_of(input logic [TimeW-1:0] v, input logic [3:0] t);
		logic [TimeW-1:0] r;
		r = v - TimeW'({t, 3'b000} + {t, 1'b0});
		return r[3:0];
	endfunction

	function automatic logic glyph_hit(input logic [3:0] d, input logic [CoordW-1:0] ox,
			input logic [CoordW-1:0] oy, input logic [CoordW-1:0] x,
			input logic [CoordW-1:0] y);
		logic [CoordW-1:0] col;
		logic [CoordW-1:0] row;
		logic [2:0]        bits;
		logic              hit;
		col = x - ox;
		row = y - oy;
		hit = 1'b0;
		if (d <= 4'd9 && x >= ox && y >= oy && col <= 4'd2 && row <= 4'd4) begin
			bits = FONT_ROWS[d][row[2:0]];
			hit  = bits[2'd2 - col[1:0]];
		end
		return hit;
	endfunction

endpackage

// ===== rtl/core/cfpr_cfg.sv =====
// ----------------------------------------------------------------------------
// cfpr_cfg
// Configuration registers: digit palette index and border gradient mode.
// ----------------------------------------------------------------------------
module cfpr_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [cfpr_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [cfpr_pkg::CfgDataW-1:0] cfg_wdata,
	output cfpr_pkg::cfg_t                 cfg
);

	cfpr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_index   <= cfpr_pkg::COLOR_INDEX_RST;
			cfg_q.gradient_mode <= cfpr_pkg::GRADIENT_MODE_RST;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				cfpr_pkg::REG_COLOR_INDEX:   cfg_q.color_index   <= cfg_wdata[1:0];
				cfpr_pkg::REG_GRADIENT_MODE: cfg_q.gradient_mode <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/cfpr_border.sv =====
// ----------------------------------------------------------------------------
// cfpr_border
// Seconds sweep on the 60 perimeter pixels: sweep index, lit test, color.
// ----------------------------------------------------------------------------
module cfpr_border (
	input  logic [cfpr_pkg::CoordW-1:0] x,
	input  logic [cfpr_pkg::CoordW-1:0] y,
	input  logic [cfpr_pkg::TimeW-1:0]  sec,
	input  logic [7:0]                  gradient_mode,
	output logic                        on_edge,
	output cfpr_pkg::rgb_t              color
);

	logic [5:0] pos;
	logic [6:0] sum;
	logic [5:0] idx;
	cfpr_pkg::rgb_t grad;

	assign on_edge = (x == 4'd0) || (x == 4'd15) || (y == 4'd0) || (y == 4'd15);

	always_comb begin
		if (y == 4'd0)       pos = {2'b00, x};
		else if (y == 4'd15) pos = 6'd45 - {2'b00, x};
		else if (x == 4'd15) pos = 6'd15 + {2'b00, y};
		else                 pos = 6'd60 - {2'b00, y};
		sum = {1'b0, pos} + 7'd52;
		idx = (sum >= 7'd60) ? 6'(sum - 7'd60) : sum[5:0];
	end

	always_comb begin
		case (gradient_mode)
			cfpr_pkg::GRAD_RAINBOW: begin
				if (idx < 6'd15)      grad = cfpr_pkg::RGB_YELLOW;
				else if (idx < 6'd30) grad = cfpr_pkg::RGB_GREEN;
				else if (idx < 6'd45) grad = cfpr_pkg::RGB_BLUE;
				else                  grad = cfpr_pkg::RGB_RED;
			end
			cfpr_pkg::GRAD_BLUE: begin
				if (idx < 6'd20)      grad = cfpr_pkg::RGB_BLUE;
				else if (idx < 6'd40) grad = cfpr_pkg::RGB_CYAN;
				else                  grad = cfpr_pkg::RGB_VIOLET;
			end
			cfpr_pkg::GRAD_WARM: begin
				if (idx < 6'd20)      grad = cfpr_pkg::RGB_RED;
				else if (idx < 6'd40) grad = cfpr_pkg::RGB_ORANGE;
				else                  grad = cfpr_pkg::RGB_YELLOW;
			end
			cfpr_pkg::GRAD_WHITE: grad = cfpr_pkg::RGB_WHITE;
			default:              grad = cfpr_pkg::RGB_WHITE;
		endcase
		color = (idx <= sec) ? grad : cfpr_pkg::RGB_BLACK;
	end

endmodule

// ===== rtl/core/cfpr_digits.sv =====
// ----------------------------------------------------------------------------
// cfpr_digits
// Hour and minute glyphs in the 3x5 font plus the blinking colon.
// ----------------------------------------------------------------------------
module cfpr_digits (
	input  logic [cfpr_pkg::CoordW-1:0] x,
	input  logic [cfpr_pkg::CoordW-1:0] y,
	input  logic [cfpr_pkg::HourW-1:0]  hr,
	input  logic [cfpr_pkg::TimeW-1:0]  mn,
	input  logic                        sec_odd,
	input  logic [1:0]                  color_index,
	output cfpr_pkg::rgb_t              color
);

	logic [3:0] h_tens, h_ones, m_tens, m_ones;
	logic       hit;

	always_comb begin
		h_tens = cfpr_pkg::tens_of({1'b0, hr});
		h_ones = cfpr_pkg::ones_of({1'b0, hr}, h_tens);
		m_tens = cfpr_pkg::tens_of(mn);
		m_ones = cfpr_pkg::ones_of(mn, m_tens);
		hit = cfpr_pkg::glyph_hit(h_tens, 4'd6,  4'd2, x, y)
			|| cfpr_pkg::glyph_hit(h_ones, 4'd10, 4'd2, x, y)
			|| cfpr_pkg::glyph_hit(m_tens, 4'd6,  4'd9, x, y)
			|| cfpr_pkg::glyph_hit(m_ones, 4'd10, 4'd9, x, y)
			|| (!sec_odd && x == 4'd4 && (y == 4'd7 || y == 4'd9));
		color = hit ? cfpr_pkg::PALETTE[color_index] : cfpr_pkg::RGB_BLACK;
	end

endmodule

// ===== rtl/core/clock_face_pixel_renderer.sv =====
// ----------------------------------------------------------------------------
// clock_face_pixel_renderer
// Color of one pixel of a 16x16 clock face for a given time.
// ----------------------------------------------------------------------------
//  channel  | signals                        | payload
//  ---------+--------------------------------+---------------------------------
//  in       | in_valid / in_stall            | in_data  (x, y, hour, min, sec)
//  out      | out_valid / out_stall          | out_data (red, green, blue)
//  config   | cfg_wen, cfg_idx               | cfg_wdata
//
// Two register stages: request register, then result register; one request
// is taken every cycle while in_stall is low.
// in_stall rises only when both stages hold requests and out_stall is high.
// Reset clears both valid flags and loads color_index 2, gradient_mode 0.
// ----------------------------------------------------------------------------
module clock_face_pixel_renderer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  cfpr_pkg::in_req_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output cfpr_pkg::rgb_t                 out_data,
	input  logic                           cfg_wen,
	input  logic [cfpr_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [cfpr_pkg::CfgDataW-1:0] cfg_wdata
);

	cfpr_pkg::cfg_t    cfg;
	cfpr_pkg::in_req_t req_s1;
	logic              vld_s1;
	cfpr_pkg::rgb_t    rgb_s2;
	logic              vld_s2;

	logic [cfpr_pkg::HourW-1:0] hr;
	logic [cfpr_pkg::TimeW-1:0] mn, sc;
	logic                       on_edge;
	cfpr_pkg::rgb_t             edge_rgb, digit_rgb, pix_rgb;
	logic                       s2_free;

	cfpr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign s2_free  = !vld_s2 || !out_stall;
	assign in_stall = vld_s1 && !s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_data;
		end
	end

	// range reduction
	always_comb begin
		hr = (req_s1.hour >= 5'd24) ? 5'(req_s1.hour - 5'd24) : req_s1.hour;
		mn = (req_s1.minute >= 6'd60) ? 6'(req_s1.minute - 6'd60) : req_s1.minute;
		sc = (req_s1.second >= 6'd60) ? 6'(req_s1.second - 6'd60) : req_s1.second;
	end

	cfpr_border u_border (
		.x             (req_s1.pixel_x),
		.y             (req_s1.pixel_y),
		.sec           (sc),
		.gradient_mode (cfg.gradient_mode),
		.on_edge       (on_edge),
		.color         (edge_rgb)
	);

	cfpr_digits u_digits (
		.x           (req_s1.pixel_x),
		.y           (req_s1.pixel_y),
		.hr          (hr),
		.mn          (mn),
		.sec_odd     (sc[0]),
		.color_index (cfg.color_index),
		.color       (digit_rgb)
	);

	assign pix_rgb = on_edge ? edge_rgb : digit_rgb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_free) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && s2_free) begin
			rgb_s2 <= pix_rgb;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = rgb_s2;

endmodule

// ===== bench/cfpr_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// cfpr_pixel_checker
// Watches the request, result and register ports of the clock face pixel
// renderer. It keeps its own copy of the two registers, works out the color
// of every accepted request and compares each accepted result with the
// oldest color still waiting.
// ----------------------------------------------------------------------------
module cfpr_pixel_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  cfpr_pkg::in_req_t             in_data,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  cfpr_pkg::rgb_t                out_data,
	input  logic                          cfg_wen,
	input  logic [cfpr_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [cfpr_pkg::CfgDataW-1:0] cfg_wdata,
	output int                            fail_count,
	output int                            in_flight
);

	localparam cfpr_pkg::rgb_t DARK    = '{8'd0,   8'd0,   8'd0};
	localparam cfpr_pkg::rgb_t C_WHITE = '{8'd255, 8'd255, 8'd255};
	localparam cfpr_pkg::rgb_t C_RED   = '{8'd255, 8'd0,   8'd0};
	localparam cfpr_pkg::rgb_t C_LIME  = '{8'd0,   8'd255, 8'd0};
	localparam cfpr_pkg::rgb_t C_BLUE  = '{8'd0,   8'd0,   8'd255};
	localparam cfpr_pkg::rgb_t C_YEL   = '{8'd255, 8'd255, 8'd0};
	localparam cfpr_pkg::rgb_t C_CYAN  = '{8'd0,   8'd255, 8'd255};
	localparam cfpr_pkg::rgb_t C_ORNG  = '{8'd255, 8'd165, 8'd0};
	localparam cfpr_pkg::rgb_t C_VIOL  = '{8'd128, 8'd0,   8'd255};

	localparam cfpr_pkg::rgb_t INK [0:3] = '{C_LIME, C_WHITE, C_CYAN, C_ORNG};

	// 3x5 glyphs, MSB is the left column
	localparam logic [2:0] GLYPH [0:9][0:4] = '{
		'{3'b111, 3'b101, 3'b101, 3'b101, 3'b111},
		'{3'b001, 3'b001, 3'b001, 3'b001, 3'b001},
		'{3'b111, 3'b001, 3'b111, 3'b100, 3'b111},
		'{3'b111, 3'b001, 3'b111, 3'b001, 3'b111},
		'{3'b101, 3'b101, 3'b111, 3'b001, 3'b001},
		'{3'b111, 3'b100, 3'b111, 3'b001, 3'b111},
		'{3'b111, 3'b100, 3'b111, 3'b101, 3'b111},
		'{3'b111, 3'b001, 3'b001, 3'b001, 3'b001},
		'{3'b111, 3'b101, 3'b111, 3'b101, 3'b111},
		'{3'b111, 3'b101, 3'b111, 3'b001, 3'b111}
	};

	logic [1:0]     palette_sel = 2'd2;
	logic [7:0]     border_mode = cfpr_pkg::GRAD_RAINBOW;
	cfpr_pkg::rgb_t expected_px [$];
	cfpr_pkg::rgb_t want;

	function automatic bit digit_lit(input int d, input int ox, input int oy,
			input int x, input int y);
		int c;
		int rw;
		c  = x - ox;
		rw = y - oy;
		if (c < 0 || c > 2 || rw < 0 || rw > 4)
			return 1'b0;
		return GLYPH[d][rw][2 - c];
	endfunction

	function automatic cfpr_pkg::rgb_t border_tint(input int idx);
		cfpr_pkg::rgb_t c;
		case (border_mode)
			cfpr_pkg::GRAD_RAINBOW: c = (idx < 15) ? C_YEL : (idx < 30) ? C_LIME :
					(idx < 45) ? C_BLUE : C_RED;
			cfpr_pkg::GRAD_BLUE:    c = (idx < 20) ? C_BLUE : (idx < 40) ? C_CYAN : C_VIOL;
			cfpr_pkg::GRAD_WARM:    c = (idx < 20) ? C_RED : (idx < 40) ? C_ORNG : C_YEL;
			default:                c = C_WHITE;
		endcase
		return c;
	endfunction

	function automatic cfpr_pkg::rgb_t pixel_color(input cfpr_pkg::in_req_t r);
		int             x, y, h, m, s, pos, idx;
		cfpr_pkg::rgb_t c;
		x = int'(r.pixel_x);
		y = int'(r.pixel_y);
		h = int'(r.hour) % 24;
		m = int'(r.minute) % 60;
		s = int'(r.second) % 60;
		c = DARK;
		if (x == 0 || x == 15 || y == 0 || y == 15) begin
			// perimeter position runs clockwise from the top-left corner
			if (y == 0)
				pos = x;
			else if (y == 15)
				pos = 45 - x;
			else if (x == 15)
				pos = 15 + y;
			else
				pos = 60 - y;
			idx = (pos + 52) % 60;
			if (idx <= s)
				c = border_tint(idx);
		end else if (digit_lit(h / 10, 6, 2, x, y) || digit_lit(h % 10, 10, 2, x, y) ||
				digit_lit(m / 10, 6, 9, x, y) || digit_lit(m % 10, 10, 9, x, y) ||
				(s % 2 == 0 && x == 4 && (y == 7 || y == 9))) begin
			c = INK[palette_sel];
		end
		return c;
	endfunction

	task automatic check_chan(input string name, input logic [7:0] exp_v,
			input logic [7:0] got);
		if (got !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_sel = 2'd2;
			border_mode = cfpr_pkg::GRAD_RAINBOW;
			expected_px.delete();
			in_flight = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_px.size() == 0) begin
					$error("result with no request waiting: %h", out_data);
					fail_count++;
				end else begin
					want = expected_px.pop_front();
					check_chan("red",   want.red,   out_data.red);
					check_chan("green", want.green, out_data.green);
					check_chan("blue",  want.blue,  out_data.blue);
				end
			end
			if (in_valid && !in_stall)
				expected_px.push_back(pixel_color(in_data));
			if (cfg_wen) begin
				case (cfg_idx)
					cfpr_pkg::REG_COLOR_INDEX:   palette_sel = cfg_wdata[1:0];
					cfpr_pkg::REG_GRADIENT_MODE: border_mode = cfg_wdata;
					default: ;
				endcase
			end
			in_flight = expected_px.size();
		end
	end

endmodule

// ===== bench/tb_clock_face_pixel_renderer.sv =====
// ----------------------------------------------------------------------------
// tb_clock_face_pixel_renderer
// Drives pixel requests into the clock face renderer: a short directed set
// of corner, sweep, digit and colon pixels, then whole-frame scans at random
// times plus scattered random pixels, under several register settings.
// Both channels idle at random. A separate checker predicts every color.
// ----------------------------------------------------------------------------
module tb_clock_face_pixel_renderer;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	cfpr_pkg::in_req_t             in_data;
	logic                          out_valid;
	logic                          out_stall;
	cfpr_pkg::rgb_t                out_data;
	logic                          cfg_wen;
	logic [cfpr_pkg::CfgIdxW-1:0]  cfg_idx;
	logic [cfpr_pkg::CfgDataW-1:0] cfg_wdata;
	int                            fail_count;
	int                            in_flight;
	bit                            no_idle = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	clock_face_pixel_renderer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	cfpr_pixel_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_wen    (cfg_wen),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.in_flight  (in_flight)
	);

	function automatic cfpr_pkg::in_req_t make_req(input int x, input int y, input int h,
			input int m, input int s);
		cfpr_pkg::in_req_t r;
		r.pixel_x = 4'(x);
		r.pixel_y = 4'(y);
		r.hour    = 5'(h);
		r.minute  = 6'(m);
		r.second  = 6'(s);
		return r;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic issue_pixel(input cfpr_pkg::in_req_t r);
		int gap;
		gap = 0;
		if (!no_idle) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
				5:             gap = $urandom_range(8, 30);
				default:       gap = 0;
			endcase
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (in_flight != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [cfpr_pkg::CfgIdxW-1:0] idx,
			input logic [cfpr_pkg::CfgDataW-1:0] data);
		cfg_wen   <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int         hold;
		bit         level;
		hold      = 0;
		level     = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				level = !no_idle && ($urandom_range(0, 2) == 0);
				if (level)
					hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
							: $urandom_range(1, 3);
				else
					hold = $urandom_range(1, 8);
			end
			out_stall <= level;
			hold--;
		end
	end

	initial begin
		cfpr_pkg::in_req_t r;
		logic [1:0]        ink;
		logic [7:0]        mode;
		int                hh, mm, ss;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_wen   = 1'b0;
		cfg_idx   = cfpr_pkg::REG_COLOR_INDEX;
		cfg_wdata = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corners and sweep ends, reset registers in effect
		issue_pixel(make_req(0, 0, 0, 0, 59));
		issue_pixel(make_req(15, 0, 0, 0, 59));
		issue_pixel(make_req(15, 15, 0, 0, 59));
		issue_pixel(make_req(0, 15, 0, 0, 59));
		issue_pixel(make_req(8, 0, 0, 0, 0));
		issue_pixel(make_req(9, 0, 0, 0, 0));
		issue_pixel(make_req(7, 0, 0, 0, 63));
		issue_pixel(make_req(10, 0, 0, 0, 63));
		issue_pixel(make_req(15, 15, 31, 63, 63));
		// digits, out-of-range hour and minute
		issue_pixel(make_req(6, 2, 31, 0, 1));
		issue_pixel(make_req(10, 2, 31, 0, 1));
		issue_pixel(make_req(11, 3, 31, 0, 1));
		issue_pixel(make_req(6, 9, 0, 63, 1));
		issue_pixel(make_req(12, 10, 0, 63, 1));
		issue_pixel(make_req(10, 10, 0, 63, 1));
		issue_pixel(make_req(8, 4, 23, 59, 1));
		issue_pixel(make_req(12, 6, 23, 59, 1));
		// colon dots and background
		issue_pixel(make_req(4, 7, 12, 34, 0));
		issue_pixel(make_req(4, 9, 12, 34, 2));
		issue_pixel(make_req(4, 9, 12, 34, 1));
		issue_pixel(make_req(4, 7, 12, 34, 61));
		issue_pixel(make_req(4, 8, 12, 34, 0));
		issue_pixel(make_req(5, 5, 12, 34, 0));
		issue_pixel(make_req(14, 14, 12, 34, 0));
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0:       begin ink = 2'd0; mode = cfpr_pkg::GRAD_RAINBOW; end
				1:       begin ink = 2'd1; mode = cfpr_pkg::GRAD_WHITE; end
				2:       begin ink = 2'd3; mode = cfpr_pkg::GRAD_BLUE; end
				3:       begin ink = 2'd2; mode = cfpr_pkg::GRAD_WARM; end
				4:       begin ink = 2'($urandom_range(0, 3)); mode = 8'd255; end
				default: begin
					ink  = 2'($urandom_range(0, 3));
					mode = 8'($urandom_range(4, 254));
				end
			endcase
			write_reg(cfpr_pkg::REG_COLOR_INDEX, {6'($urandom_range(0, 63)), ink});
			write_reg(cfpr_pkg::REG_GRADIENT_MODE, mode);
			no_idle = (ph == 1);

			// full frame scan at one random time
			hh = $urandom_range(0, 31);
			mm = $urandom_range(0, 63);
			ss = $urandom_range(0, 63);
			for (int y = 0; y < 16; y++)
				for (int x = 0; x < 16; x++)
					issue_pixel(make_req(x, y, hh, mm, ss));
			no_idle = 1'b0;

			// scattered pixels
			for (int k = 0; k < 30; k++) begin
				r.pixel_x = 4'($urandom_range(0, 15));
				r.pixel_y = 4'($urandom_range(0, 15));
				r.hour    = 5'($urandom_range(0, 31));
				r.minute  = 6'($urandom_range(0, 63));
				r.second  = 6'($urandom_range(0, 63));
				issue_pixel(r);
			end
			settle();
		end

		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#12000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
